@@ sv/bec_pkg.sv @@
// ----------------------------------------------------------------------------
// bec_pkg: shared types and control store for the bridge edge checker
// step codes, condition codes, control word layout and the microcode table
// ----------------------------------------------------------------------------
`default_nettype none

package bec_pkg;

  // default graph size and fixed field widths
  localparam int MAX_VERTICES_DEF = 32;
  localparam int VERTEX_W         = 5;
  localparam int VCOUNT_W         = 6;
  localparam int CFG_ADDR_W       = 3;
  localparam int CFG_DATA_W       = 32;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 6'd32;

  // register index codes (byte address bit 2)
  localparam logic REG_VERTEX_COUNT = 1'b0;

  // transaction kinds
  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // sequencer steps
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ADD_RD,
    ST_ADD_WA,
    ST_ADD_WB,
    ST_Q_INIT,
    ST_POP,
    ST_FETCH,
    ST_LOAD,
    ST_PUSH,
    ST_OUT
  } step_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NONE,
    C_NO_START,
    C_KIND_QUERY,
    C_AB_OUT,
    C_A_OUT,
    C_SP_ZERO,
    C_NEXT_ZERO
  } cond_t;

  // adjacency read address select
  typedef enum logic [1:0] {
    RD_NONE,
    RD_A,
    RD_B,
    RD_S
  } rd_sel_t;

  // adjacency write address select
  typedef enum logic [1:0] {
    WR_NONE,
    WR_A,
    WR_B
  } wr_sel_t;

  // one control word: jump when cond holds, else go to nxt
  typedef struct packed {
    cond_t   cond;
    step_t   jmp;
    step_t   nxt;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    walk_init;
    logic    pop;
    logic    load_next;
    logic    push;
    logic    emit;
  } ucw_t;

  // control store
  function automatic ucw_t ucode(input step_t s);
    ucw_t w;
    w           = '0;
    w.cond      = C_NONE;
    w.jmp       = ST_IDLE;
    w.nxt       = ST_IDLE;
    w.rd_sel    = RD_NONE;
    w.wr_sel    = WR_NONE;
    unique case (s)
      ST_IDLE: begin
        w.cond = C_NO_START;
        w.jmp  = ST_IDLE;
        w.nxt  = ST_DECODE;
      end
      ST_DECODE: begin
        w.cond = C_KIND_QUERY;
        w.jmp  = ST_Q_INIT;
        w.nxt  = ST_ADD_RD;
      end
      ST_ADD_RD: begin
        w.cond   = C_AB_OUT;
        w.jmp    = ST_IDLE;
        w.nxt    = ST_ADD_WA;
        w.rd_sel = RD_A;
      end
      ST_ADD_WA: begin
        w.nxt    = ST_ADD_WB;
        w.wr_sel = WR_A;
        w.rd_sel = RD_B;
      end
      ST_ADD_WB: begin
        w.nxt    = ST_IDLE;
        w.wr_sel = WR_B;
      end
      ST_Q_INIT: begin
        w.cond      = C_A_OUT;
        w.jmp       = ST_OUT;
        w.nxt       = ST_POP;
        w.walk_init = 1'b1;
      end
      ST_POP: begin
        w.cond = C_SP_ZERO;
        w.jmp  = ST_OUT;
        w.nxt  = ST_FETCH;
        w.pop  = 1'b1;
      end
      ST_FETCH: begin
        w.nxt    = ST_LOAD;
        w.rd_sel = RD_S;
      end
      ST_LOAD: begin
        w.nxt       = ST_PUSH;
        w.load_next = 1'b1;
      end
      ST_PUSH: begin
        w.cond = C_NEXT_ZERO;
        w.jmp  = ST_POP;
        w.nxt  = ST_PUSH;
        w.push = 1'b1;
      end
      ST_OUT: begin
        w.nxt  = ST_IDLE;
        w.emit = 1'b1;
      end
      default: begin
        w.nxt = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ sv/bridge_edge_check.sv @@
// ----------------------------------------------------------------------------
// bridge_edge_check: bridge test on an undirected graph by edge removal
// keeps an adjacency bit matrix, adds edges and answers bridge queries with a
// depth-first walk driven by a microcoded sequencer
// ----------------------------------------------------------------------------
//
//  channel   handshake             fields
//  --------  --------------------  -----------------------------------------
//  input     start / busy          in_kind, in_first_vertex, in_second_vertex
//  result    out_valid (strobe)    out_is_bridge, out_reached_count
//  config    psel/penable/pwrite   paddr, pwdata, prdata, pready
//
//  an add transaction holds busy through decode, a row read and two writes;
//  a query holds busy while it walks the vertices reached, and each popped
//  vertex costs a pop with stack read, a row read, a row load, one push per
//  pushed neighbor and one step to see none left
//  the result strobe is high for one cycle, the first cycle with busy low
//  reset clears the adjacency row valid bits, so the matrix reads empty at once
//  the receiver cannot stall; results are never held
//
`default_nettype none

module bridge_edge_check #(
  parameter int MAX_VERTICES = bec_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input transaction
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                in_kind,
  input  wire logic [bec_pkg::VERTEX_W-1:0]        in_first_vertex,
  input  wire logic [bec_pkg::VERTEX_W-1:0]        in_second_vertex,
  // result transaction
  output logic                                     out_valid,
  output logic                                     out_is_bridge,
  output logic [bec_pkg::VCOUNT_W-1:0]             out_reached_count,
  // register port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [bec_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire logic [bec_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [bec_pkg::CFG_DATA_W-1:0]           prdata,
  output logic                                     pready
);

  localparam int MV = MAX_VERTICES;
  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  // sequencer
  bec_pkg::step_t pc_r, pc_nxt;
  bec_pkg::ucw_t  uw;
  logic           cond_hit;

  // latched transaction
  logic                         kind_r;
  logic [bec_pkg::VERTEX_W-1:0] a_r, b_r;
  logic                         a_ok, b_ok;
  logic [VW-1:0]                a_idx, b_idx;

  // adjacency memory and its row valid bits
  logic [MV-1:0] adj_mem [MV];
  logic [MV-1:0] adj_vld_r;
  logic [MV-1:0] adj_rd_r;
  logic          adj_rv_r;
  logic [MV-1:0] row_now;
  logic          rd_en, wr_en;
  logic [VW-1:0] rd_addr, wr_addr;
  logic [MV-1:0] wr_data;

  // walk stack memory
  logic [VW-1:0] stk_mem [MV];
  logic [VW-1:0] stk_rd_r;
  logic          stk_we;
  logic [VW-1:0] stk_waddr, stk_wdata;

  // walk state
  logic [CW-1:0] sp_r, sp_m1;
  logic [CW-1:0] tally_r;
  logic [MV-1:0] visited_r, next_r;
  logic [MV-1:0] low_bit, y_mask;
  logic [VW-1:0] low_idx;
  logic          pop_go, push_go, sp_full;

  // result and register
  logic                         out_valid_r, out_is_bridge_r;
  logic [bec_pkg::VCOUNT_W-1:0] out_reached_r;
  logic [bec_pkg::VCOUNT_W-1:0] vcount_r;
  logic                         cfg_wr;

  // control word fetch and jump decision
  always_comb begin
    uw = bec_pkg::ucode(pc_r);
    unique case (uw.cond)
      bec_pkg::C_NONE:       cond_hit = 1'b0;
      bec_pkg::C_NO_START:   cond_hit = !start;
      bec_pkg::C_KIND_QUERY: cond_hit = (kind_r == bec_pkg::KIND_QUERY);
      bec_pkg::C_AB_OUT:     cond_hit = !(a_ok && b_ok);
      bec_pkg::C_A_OUT:      cond_hit = !a_ok;
      bec_pkg::C_SP_ZERO:    cond_hit = (sp_r == '0);
      bec_pkg::C_NEXT_ZERO:  cond_hit = (next_r == '0);
      default:               cond_hit = 1'b0;
    endcase
    pc_nxt = cond_hit ? uw.jmp : uw.nxt;
  end

  // sequencer outputs
  always_comb begin
    busy = (pc_r != bec_pkg::ST_IDLE);
  end

  // vertex range checks and indexes
  assign a_ok  = (32'(a_r) < MAX_VERTICES);
  assign b_ok  = (32'(b_r) < MAX_VERTICES);
  assign a_idx = VW'(a_r);
  assign b_idx = VW'(b_r);

  // row read as seen through the valid bit
  assign row_now = adj_rv_r ? adj_rd_r : '0;

  // adjacency port selects
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    unique case (uw.rd_sel)
      bec_pkg::RD_A: rd_addr = a_idx;
      bec_pkg::RD_B: rd_addr = b_idx;
      bec_pkg::RD_S: rd_addr = stk_rd_r;
      default:       rd_en   = 1'b0;
    endcase
    wr_en   = 1'b1;
    wr_addr = '0;
    wr_data = '0;
    unique case (uw.wr_sel)
      bec_pkg::WR_A: begin
        wr_addr = a_idx;
        wr_data = row_now | (MV'(1) << b_idx);
      end
      bec_pkg::WR_B: begin
        wr_addr = b_idx;
        wr_data = row_now | (MV'(1) << a_idx);
      end
      default: wr_en = 1'b0;
    endcase
  end

  // removed edge applies only on the start vertex row
  assign y_mask = (b_ok && (stk_rd_r == a_idx)) ? (MV'(1) << b_idx) : '0;

  // lowest pending neighbor
  assign low_bit = next_r & (~next_r + MV'(1));
  always_comb begin
    low_idx = '0;
    for (int i = 0; i < MV; i++) begin
      if (low_bit[i]) begin
        low_idx = low_idx | VW'(i);
      end
    end
  end

  // stack controls
  assign sp_m1   = sp_r - CW'(1);
  assign sp_full = (32'(sp_r) >= MAX_VERTICES);
  assign pop_go  = uw.pop && (sp_r != '0);
  assign push_go = uw.push && (next_r != '0);

  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = '0;
    stk_wdata = '0;
    if (uw.walk_init && a_ok) begin
      stk_we    = 1'b1;
      stk_wdata = a_idx;
    end else if (push_go && !sp_full) begin
      stk_we    = 1'b1;
      stk_waddr = sp_r[VW-1:0];
      stk_wdata = low_idx;
    end
  end

  // adjacency memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      adj_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      adj_rd_r <= adj_mem[rd_addr];
      adj_rv_r <= adj_vld_r[rd_addr];
    end
  end

  // walk stack memory
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (pop_go) begin
      stk_rd_r <= stk_mem[sp_m1[VW-1:0]];
    end
  end

  // transaction latch and pending neighbor set
  always_ff @(posedge clk) begin
    if ((pc_r == bec_pkg::ST_IDLE) && start) begin
      kind_r <= in_kind;
      a_r    <= in_first_vertex;
      b_r    <= in_second_vertex;
    end
    if (uw.load_next) begin
      next_r <= row_now & ~visited_r & ~y_mask;
    end else if (push_go) begin
      next_r <= next_r & ~low_bit;
    end
    if (uw.emit) begin
      out_is_bridge_r <= (32'(tally_r) != 32'(vcount_r));
      out_reached_r   <= (32'(tally_r) > 32'd63) ? 6'd63 : bec_pkg::VCOUNT_W'(tally_r);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= bec_pkg::ST_IDLE;
      adj_vld_r   <= '0;
      sp_r        <= '0;
      tally_r     <= '0;
      visited_r   <= '0;
      out_valid_r <= 1'b0;
      vcount_r    <= bec_pkg::VCOUNT_RST;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= uw.emit;
      if (wr_en) begin
        adj_vld_r[wr_addr] <= 1'b1;
      end
      if (cfg_wr) begin
        vcount_r <= pwdata[bec_pkg::VCOUNT_W-1:0];
      end
      if (uw.walk_init) begin
        visited_r <= a_ok ? (MV'(1) << a_idx) : '0;
        tally_r   <= a_ok ? CW'(1) : '0;
        sp_r      <= a_ok ? CW'(1) : '0;
      end else if (pop_go) begin
        sp_r <= sp_m1;
      end else if (push_go) begin
        visited_r <= visited_r | low_bit;
        tally_r   <= tally_r + CW'(1);
        if (!sp_full) begin
          sp_r <= sp_r + CW'(1);
        end
      end
    end
  end

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == bec_pkg::REG_VERTEX_COUNT);
  assign prdata = (paddr[2] == bec_pkg::REG_VERTEX_COUNT) ?
                  bec_pkg::CFG_DATA_W'(vcount_r) : '0;

  // result ports
  assign out_valid         = out_valid_r;
  assign out_is_bridge     = out_is_bridge_r;
  assign out_reached_count = out_reached_r;

  // checks
  a_strobe_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_strobe_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while the sequencer is busy");

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_reached_count) <= MAX_VERTICES))
    else $error("reached count above the graph size");

  a_stack_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (32'(sp_r) <= MAX_VERTICES) && (32'(tally_r) <= MAX_VERTICES))
    else $error("walk stack or tally overran the graph size");

endmodule

`default_nettype wire

@@ tb/sv/bridge_edge_check_tb.sv @@
// ----------------------------------------------------------------------------
// bridge_edge_check_tb: self-checking bench for the bridge edge checker
// drives add and query transactions, predicts every query answer from a
// private copy of the adjacency matrix and compares each result strobe
// ----------------------------------------------------------------------------
module bridge_edge_check_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // unused register index, writes there must not land anywhere
  localparam logic REG_SPARE = 1'b1;

  localparam int VW         = bec_pkg::VERTEX_W;
  localparam int ANS_DEPTH  = 8;
  localparam int ANS_IW     = $clog2(ANS_DEPTH);
  localparam int LINK_DEPTH = 512;
  localparam int LINK_IW    = $clog2(LINK_DEPTH);

  typedef struct packed {
    logic                         is_bridge;
    logic [bec_pkg::VCOUNT_W-1:0] reached;
  } answer_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                            start = 1'b0;
  logic                            busy;
  logic                            in_kind = bec_pkg::KIND_ADD;
  logic [VW-1:0]                   in_first_vertex = '0;
  logic [VW-1:0]                   in_second_vertex = '0;
  logic                            out_valid;
  logic                            out_is_bridge;
  logic [bec_pkg::VCOUNT_W-1:0]    out_reached_count;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [bec_pkg::CFG_ADDR_W-1:0]  paddr = '0;
  logic [bec_pkg::CFG_DATA_W-1:0]  pwdata = '0;
  logic [bec_pkg::CFG_DATA_W-1:0]  prdata;
  logic                            pready;

  // private graph copy, register copy and answers still in flight
  logic [bec_pkg::MAX_VERTICES_DEF-1:0] graph_rows [bec_pkg::MAX_VERTICES_DEF];
  logic [bec_pkg::VCOUNT_W-1:0]         vertex_count_model = bec_pkg::VCOUNT_RST;
  answer_t                              ans_fifo [ANS_DEPTH];
  logic [ANS_IW-1:0]                    ans_wr_ptr = '0;
  logic [ANS_IW-1:0]                    ans_rd_ptr = '0;
  int                                   ans_level = 0;
  logic [2*VW-1:0]                      links [LINK_DEPTH];
  int                                   link_count = 0;
  answer_t                              oldest;
  int                                   idle_pct = 18;
  int                                   fail_count = 0;

  bridge_edge_check dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_first_vertex   (in_first_vertex),
    .in_second_vertex  (in_second_vertex),
    .out_valid         (out_valid),
    .out_is_bridge     (out_is_bridge),
    .out_reached_count (out_reached_count),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(20_000_000);
    $display("status: fail");
    $finish;
  end

  // vertices reachable from x once the edge x-y is taken out
  function automatic int reach_from(input logic [VW-1:0] x,
                                    input logic [VW-1:0] y);
    logic [bec_pkg::MAX_VERTICES_DEF-1:0] seen;
    logic [bec_pkg::MAX_VERTICES_DEF-1:0] grown;
    logic [bec_pkg::MAX_VERTICES_DEF-1:0] row;
    seen = '0;
    seen[x] = 1'b1;
    do begin
      grown = seen;
      for (int v = 0; v < bec_pkg::MAX_VERTICES_DEF; v++) begin
        if (seen[v]) begin
          row = graph_rows[v];
          if (v == x) row[y] = 1'b0;
          grown |= row;
        end
      end
      if (grown == seen) break;
      seen = grown;
    end while (1);
    return $countones(seen);
  endfunction

  // answer ring, filled at acceptance and emptied by the checker
  function automatic void queue_answer(input answer_t ans);
    ans_fifo[ans_wr_ptr] = ans;
    ans_wr_ptr = ans_wr_ptr + ANS_IW'(1);
    ans_level++;
  endfunction

  // link list used to pick edges for queries
  function automatic void add_link(input logic [2*VW-1:0] lk);
    if (link_count < LINK_DEPTH) begin
      links[LINK_IW'(link_count)] = lk;
      link_count++;
    end
  endfunction

  // one input transaction, with random sender gaps
  task automatic send_item(input logic kind, input logic [VW-1:0] a,
                           input logic [VW-1:0] b);
    int      reach;
    answer_t ans;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
    start            <= 1'b1;
    in_kind          <= kind;
    in_first_vertex  <= a;
    in_second_vertex <= b;
    do @(posedge clk); while (busy);
    // accepted at this edge: update the graph or queue the answer
    if (kind == bec_pkg::KIND_ADD) begin
      graph_rows[a][b] = 1'b1;
      graph_rows[b][a] = 1'b1;
    end else begin
      reach = reach_from(a, b);
      ans.is_bridge = (bec_pkg::VCOUNT_W'(reach) != vertex_count_model);
      ans.reached   = bec_pkg::VCOUNT_W'(reach);
      queue_answer(ans);
    end
  endtask

  // stop sending and let the block go quiet
  task automatic drain_results();
    start <= 1'b0;
    while (ans_level != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // register write followed by a read back of vertex_count
  task automatic cfg_write(input logic idx, input logic [bec_pkg::CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == bec_pkg::REG_VERTEX_COUNT) begin
      vertex_count_model = data[bec_pkg::VCOUNT_W-1:0];
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {bec_pkg::REG_VERTEX_COUNT, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[bec_pkg::VCOUNT_W-1:0] !== vertex_count_model) begin
      $display("%0t: vertex_count read back expected %0d got %0d",
               $time, vertex_count_model, prdata[bec_pkg::VCOUNT_W-1:0]);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // empty graph, self-loop, repeated edge, missing edge, one-way removal
  task automatic test_edge_cases();
    send_item(bec_pkg::KIND_QUERY, 5'd0, 5'd0);
    send_item(bec_pkg::KIND_ADD, 5'd0, 5'd31);
    send_item(bec_pkg::KIND_ADD, 5'd31, 5'd31);
    send_item(bec_pkg::KIND_ADD, 5'd31, 5'd0);
    send_item(bec_pkg::KIND_QUERY, 5'd0, 5'd31);
    send_item(bec_pkg::KIND_QUERY, 5'd31, 5'd0);
    send_item(bec_pkg::KIND_QUERY, 5'd31, 5'd31);
    send_item(bec_pkg::KIND_QUERY, 5'd31, 5'd7);
    send_item(bec_pkg::KIND_QUERY, 5'd7, 5'd31);
    send_item(bec_pkg::KIND_ADD, 5'd7, 5'd0);
    send_item(bec_pkg::KIND_QUERY, 5'd0, 5'd7);
    send_item(bec_pkg::KIND_QUERY, 5'd31, 5'd0);
    send_item(bec_pkg::KIND_QUERY, 5'd7, 5'd7);
  endtask

  // vertex_count extremes, out of range values and the spare address
  task automatic test_register_settings();
    drain_results();
    cfg_write(bec_pkg::REG_VERTEX_COUNT, 32'd2);
    send_item(bec_pkg::KIND_QUERY, 5'd0, 5'd7);
    drain_results();
    cfg_write(bec_pkg::REG_VERTEX_COUNT, 32'd1);
    send_item(bec_pkg::KIND_QUERY, 5'd7, 5'd0);
    drain_results();
    cfg_write(bec_pkg::REG_VERTEX_COUNT, 32'd0);
    send_item(bec_pkg::KIND_QUERY, 5'd0, 5'd0);
    drain_results();
    cfg_write(bec_pkg::REG_VERTEX_COUNT, 32'hffff_ffff);
    send_item(bec_pkg::KIND_QUERY, 5'd31, 5'd31);
    drain_results();
    cfg_write(REG_SPARE, 32'd3);
    send_item(bec_pkg::KIND_QUERY, 5'd0, 5'd0);
    drain_results();
    cfg_write(bec_pkg::REG_VERTEX_COUNT, 32'hAAAA_AA83);
    send_item(bec_pkg::KIND_QUERY, 5'd0, 5'd0);
    send_item(bec_pkg::KIND_QUERY, 5'd0, 5'd31);
  endtask

  // spanning tree over a vertex window, then chords and queries on its links
  task automatic test_growing_graph(input int lo, input int hi, input int count);
    int                            u;
    int                            r;
    logic [2*VW-1:0]               lk;
    logic [bec_pkg::CFG_DATA_W-1:0] data;
    link_count = 0;
    // tree links are added and queried one by one while they are made
    for (int v = lo + 1; v <= hi; v++) begin
      u = $urandom_range(v - 1, lo);
      send_item(bec_pkg::KIND_ADD, VW'(v), VW'(u));
      add_link({VW'(v), VW'(u)});
      lk = links[LINK_IW'($urandom_range(link_count - 1))];
      send_item(bec_pkg::KIND_QUERY, lk[2*VW-1:VW], lk[VW-1:0]);
    end
    // a connected window lets non-bridge answers appear
    drain_results();
    data = $urandom();
    data[bec_pkg::VCOUNT_W-1:0] = bec_pkg::VCOUNT_W'(reach_from(VW'(lo), VW'(lo)));
    cfg_write(bec_pkg::REG_VERTEX_COUNT, data);
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 4) begin
        u = $urandom_range(hi, lo);
        lk = {VW'($urandom_range(hi, lo)), VW'(u)};
        send_item(bec_pkg::KIND_ADD, lk[2*VW-1:VW], lk[VW-1:0]);
        add_link(lk);
      end else if (r < 86) begin
        lk = links[LINK_IW'($urandom_range(link_count - 1))];
        if ($urandom_range(1))
          send_item(bec_pkg::KIND_QUERY, lk[2*VW-1:VW], lk[VW-1:0]);
        else
          send_item(bec_pkg::KIND_QUERY, lk[VW-1:0], lk[2*VW-1:VW]);
      end else if (r < 94) begin
        send_item(bec_pkg::KIND_QUERY, VW'($urandom_range(hi, lo)),
                  VW'($urandom_range(hi, lo)));
      end else begin
        send_item(bec_pkg::KIND_QUERY, VW'($urandom_range(31)), VW'($urandom_range(31)));
      end
    end
  endtask

  // compare each result transaction with the oldest queued answer
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (ans_level == 0) begin
        $display("%0t: unexpected result, expected none got bridge %0b count %0d",
                 $time, out_is_bridge, out_reached_count);
        fail_count++;
      end else begin
        oldest = ans_fifo[ans_rd_ptr];
        ans_rd_ptr = ans_rd_ptr + ANS_IW'(1);
        ans_level--;
        if (out_is_bridge !== oldest.is_bridge) begin
          $display("%0t: is_bridge expected %0b got %0b",
                   $time, oldest.is_bridge, out_is_bridge);
          fail_count++;
        end
        if (out_reached_count !== oldest.reached) begin
          $display("%0t: reached_count expected %0d got %0d",
                   $time, oldest.reached, out_reached_count);
          fail_count++;
        end
      end
    end
  end

  // test sequence
  initial begin
    for (int v = 0; v < bec_pkg::MAX_VERTICES_DEF; v++) graph_rows[v] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_edge_cases();
    test_register_settings();
    idle_pct = 18;
    test_growing_graph(8, 19, 350);
    idle_pct = 50;
    test_growing_graph(20, 30, 350);
    idle_pct = 0;
    test_growing_graph(0, 31, 350);
    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
